// ----- hdl/pmks_pkg.sv -----
// ----------------------------------------------------------------------------
// pmks_pkg
// Shared types and constants of the k-nearest patch selection core.
// ----------------------------------------------------------------------------
package pmks_pkg;

	localparam int KEEP_MAX    = 16;
	localparam int SAMPLE_W    = 16;
	localparam int INDEX_W     = 20;
	localparam int DIST_W      = 38;
	localparam int SQ_W        = 2 * SAMPLE_W;
	localparam int SEL_W       = 5;
	localparam int CNT_W       = $clog2(KEEP_MAX + 1);
	localparam int SLOT_W      = (KEEP_MAX > 1) ? $clog2(KEEP_MAX) : 1;
	localparam int LIM_W       = (CNT_W > SEL_W) ? CNT_W : SEL_W;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;

	localparam logic [SEL_W-1:0] SELECT_COUNT_RESET = SEL_W'(8);
	localparam logic             REG_SELECT_COUNT   = 1'b0;

	typedef struct packed {
		logic [DIST_W-1:0]  distance;
		logic [INDEX_W-1:0] index;
		logic               window_end;
	} cand_entry_t;

	typedef struct packed {
		logic [QCNT_W-1:0] count;
		logic              empty;
	} queue_status_t;

	typedef enum logic {
		BK_INSERT,
		BK_EMIT
	} back_state_t;

endpackage

// ----- hdl/patch_match_k_nearest_select_core.sv -----
// ----------------------------------------------------------------------------
// patch_match_k_nearest_select_core
// Block matching: sums squared differences per candidate patch and keeps the
// select_count nearest candidates of each window, emitted in ascending order.
// ----------------------------------------------------------------------------
//  channel   handshake                      payload
//  samples   start / busy                   cand_sample ref_sample cand_index
//                                           patch_last window_last
//  matches   match_valid (strobe)           match_index match_distance last_match
//  config    psel penable pwrite pready     paddr pwdata prdata
//
// Samples are taken one per cycle while busy is low; a patch end makes the back end
// enter the candidate into its sorted list, through a four-entry queue.
// A window end makes the back end emit its kept candidates one per cycle;
// busy rises once the queue holds four candidates, counting one about to enter
// it, and holds input back until an entry leaves the queue.
// Results are registered behind the sample stage, queue and sorted list; the
// receiver cannot stall. Reset clears the control state at once, with no clearing pass.
// ----------------------------------------------------------------------------
module patch_match_k_nearest_select_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [pmks_pkg::SAMPLE_W-1:0] cand_sample,
	input  logic [pmks_pkg::SAMPLE_W-1:0] ref_sample,
	input  logic [pmks_pkg::INDEX_W-1:0]  cand_index,
	input  logic                          patch_last,
	input  logic                          window_last,
	output logic                          match_valid,
	output logic [pmks_pkg::INDEX_W-1:0]  match_index,
	output logic [pmks_pkg::DIST_W-1:0]   match_distance,
	output logic                          last_match,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pmks_pkg::PADDR_W-1:0]  paddr,
	input  logic [pmks_pkg::PDATA_W-1:0]  pwdata,
	output logic [pmks_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import pmks_pkg::*;

	logic             push;
	cand_entry_t      push_entry;
	cand_entry_t      head;
	queue_status_t    q_status;
	logic             pop;
	logic [SEL_W-1:0] select_count_q;
	logic             reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			select_count_q <= SELECT_COUNT_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel == REG_SELECT_COUNT) begin
			select_count_q <= pwdata[SEL_W-1:0];
		end
	end

	assign prdata = (reg_sel == REG_SELECT_COUNT) ? PDATA_W'(select_count_q) : '0;

	pmks_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cand_sample (cand_sample),
		.ref_sample  (ref_sample),
		.cand_index  (cand_index),
		.patch_last  (patch_last),
		.window_last (window_last),
		.q_status    (q_status),
		.push        (push),
		.push_entry  (push_entry)
	);

	pmks_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.status     (q_status)
	);

	pmks_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.q_empty        (q_status.empty),
		.select_count   (select_count_q),
		.pop            (pop),
		.match_valid    (match_valid),
		.match_index    (match_index),
		.match_distance (match_distance),
		.last_match     (last_match)
	);

endmodule

// ----- hdl/pmks_front.sv -----
// ----------------------------------------------------------------------------
// pmks_front
// Accepts sample pairs, squares their difference and accumulates each patch;
// a finished patch is pushed to the candidate queue.
// ----------------------------------------------------------------------------
module pmks_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [pmks_pkg::SAMPLE_W-1:0] cand_sample,
	input  logic [pmks_pkg::SAMPLE_W-1:0] ref_sample,
	input  logic [pmks_pkg::INDEX_W-1:0]  cand_index,
	input  logic                          patch_last,
	input  logic                          window_last,
	input  pmks_pkg::queue_status_t       q_status,
	output logic                          push,
	output pmks_pkg::cand_entry_t         push_entry
);
	import pmks_pkg::*;

	logic                accept;
	logic [SAMPLE_W-1:0] diff;
	logic [SQ_W-1:0]     sq;
	logic                valid_s1;
	logic [SQ_W-1:0]     sq_s1;
	logic [INDEX_W-1:0]  index_s1;
	logic                end_s1;
	logic                wlast_s1;
	logic [DIST_W-1:0]   sum_q;
	logic [DIST_W:0]     sum_wide;
	logic [DIST_W-1:0]   sum_sat;
	logic [QCNT_W:0]     committed;

	assign committed = {1'b0, q_status.count} + {{QCNT_W{1'b0}}, valid_s1 & end_s1};
	assign busy      = committed >= (QCNT_W + 1)'(QUEUE_DEPTH);
	assign accept    = start & ~busy;

	assign diff = (cand_sample >= ref_sample) ? (cand_sample - ref_sample)
	                                          : (ref_sample - cand_sample);
	assign sq   = {{SAMPLE_W{1'b0}}, diff} * {{SAMPLE_W{1'b0}}, diff};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sq_s1    <= sq;
			index_s1 <= cand_index;
			end_s1   <= patch_last | window_last;
			wlast_s1 <= window_last;
		end
	end

	assign sum_wide = {1'b0, sum_q} + (DIST_W + 1)'(sq_s1);
	assign sum_sat  = sum_wide[DIST_W] ? {DIST_W{1'b1}} : sum_wide[DIST_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (valid_s1) begin
			sum_q <= end_s1 ? '0 : sum_sat;
		end
	end

	assign push                  = valid_s1 & end_s1;
	assign push_entry.distance   = sum_sat;
	assign push_entry.index      = index_s1;
	assign push_entry.window_end = wlast_s1;

endmodule

// ----- hdl/pmks_queue.sv -----
// ----------------------------------------------------------------------------
// pmks_queue
// Short first-in first-out queue of finished candidates between front and
// back.
// ----------------------------------------------------------------------------
module pmks_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  pmks_pkg::cand_entry_t   push_entry,
	input  logic                    pop,
	output pmks_pkg::cand_entry_t   head,
	output pmks_pkg::queue_status_t status
);
	import pmks_pkg::*;

	cand_entry_t       slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	assign head         = slots_q[rd_ptr_q];
	assign status.count = count_q;
	assign status.empty = (count_q == '0);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != QCNT_W'(QUEUE_DEPTH)) || pop)
		else $error("Candidate queue written while full.");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("Candidate queue read while empty.");

endmodule

// ----- hdl/pmks_back.sv -----
// ----------------------------------------------------------------------------
// pmks_back
// Keeps the sorted list of the nearest candidates and emits it, one entry a
// cycle, at the end of each window.
// ----------------------------------------------------------------------------
module pmks_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pmks_pkg::cand_entry_t         head,
	input  logic                          q_empty,
	input  logic [pmks_pkg::SEL_W-1:0]    select_count,
	output logic                          pop,
	output logic                          match_valid,
	output logic [pmks_pkg::INDEX_W-1:0]  match_index,
	output logic [pmks_pkg::DIST_W-1:0]   match_distance,
	output logic                          last_match
);
	import pmks_pkg::*;

	back_state_t        state_q;
	back_state_t        state_d;
	logic               emit;
	logic [DIST_W-1:0]  dist_q  [KEEP_MAX];
	logic [INDEX_W-1:0] index_q [KEEP_MAX];
	logic [CNT_W-1:0]   kept_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [LIM_W-1:0]   sel_wide;
	logic [CNT_W-1:0]   limit;
	logic [CNT_W-1:0]   kept_cut;
	logic               full;
	logic [CNT_W-1:0]   limit_m1;
	logic [DIST_W-1:0]  worst;
	logic               enter;
	logic [CNT_W-1:0]   kept_base;
	logic [KEEP_MAX-1:0] stay;
	logic               emit_last;

	assign sel_wide = LIM_W'(select_count);
	always_comb begin
		if (sel_wide == '0) begin
			limit = CNT_W'(1);
		end else if (sel_wide > LIM_W'(KEEP_MAX)) begin
			limit = CNT_W'(KEEP_MAX);
		end else begin
			limit = sel_wide[CNT_W-1:0];
		end
	end

	assign kept_cut  = (kept_q > limit) ? limit : kept_q;
	assign full      = (kept_cut == limit);
	assign limit_m1  = limit - 1'b1;
	assign worst     = dist_q[limit_m1[SLOT_W-1:0]];
	assign enter     = ~full | (head.distance < worst);
	assign kept_base = full ? limit_m1 : kept_cut;

	always_comb begin
		for (int i = 0; i < KEEP_MAX; i++) begin
			stay[i] = (CNT_W'(i) < kept_base) && (dist_q[i] <= head.distance);
		end
	end

	assign emit_last = (CNT_W'(slot_q) + 1'b1) == kept_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_INSERT: begin
				if (!q_empty && head.window_end) begin
					state_d = BK_EMIT;
				end
			end
			BK_EMIT: begin
				if (emit_last) begin
					state_d = BK_INSERT;
				end
			end
			default: state_d = BK_INSERT;
		endcase
	end

	always_comb begin
		pop  = 1'b0;
		emit = 1'b0;
		unique case (state_q)
			BK_INSERT: pop  = ~q_empty;
			BK_EMIT:   emit = 1'b1;
			default: begin
				pop  = 1'b0;
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_INSERT;
			kept_q      <= '0;
			slot_q      <= '0;
			match_valid <= 1'b0;
		end else begin
			state_q     <= state_d;
			match_valid <= emit;
			if (pop) begin
				if (enter) begin
					kept_q <= kept_base + 1'b1;
				end else begin
					kept_q <= kept_cut;
				end
			end else if (emit && emit_last) begin
				kept_q <= '0;
			end
			if (emit) begin
				slot_q <= emit_last ? '0 : slot_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && enter) begin
			for (int i = 0; i < KEEP_MAX; i++) begin
				if (!stay[i]) begin
					if (i == 0 || stay[(i == 0) ? 0 : i - 1]) begin
						dist_q[i]  <= head.distance;
						index_q[i] <= head.index;
					end else begin
						dist_q[i]  <= dist_q[(i == 0) ? 0 : i - 1];
						index_q[i] <= index_q[(i == 0) ? 0 : i - 1];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			match_index    <= index_q[slot_q];
			match_distance <= dist_q[slot_q];
			last_match     <= emit_last;
		end
	end

	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(match_valid && last_match) |=> !match_valid)
		else $error("Result strobe continued past the final match.");

	a_kept_bound: assert property (@(posedge clk) disable iff (!arst_n)
		kept_q <= CNT_W'(KEEP_MAX))
		else $error("Kept list count exceeds its capacity.");

	a_no_pop_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> !pop)
		else $error("Candidate taken during list emission.");

endmodule
